### hw/rtl/imu_tlv_pkg.sv
// Package for the IMU frame TLV parser: phase codes, record table, sizes.
// No dependencies.
package imu_tlv_pkg;

  localparam int MaxRecordBytes = 20;
  localparam int RecCountW = 5;
  localparam int QueueDepth = 2;

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_TID0, PH_TID1, PH_LEN,
    PH_RID, PH_RLEN, PH_RDATA, PH_CK1, PH_CK2
  } phase_t;

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_index_t;

  // One classified event handed from the front part to the back part.
  typedef struct packed {
    logic                            is_frame;
    logic [7:0]                      id;
    logic [MaxRecordBytes*8-1:0]     data;
    logic                            ok;
    logic [15:0]                     tid;
  } event_t;

  // Expected data length of a record id; zero for unknown ids.
  function automatic logic [7:0] expected_len(input logic [7:0] id);
    logic [7:0] len;
    len = 8'd0;
    case (id)
      8'h01: len = 8'd2;
      8'h10, 8'h20, 8'h30, 8'h31, 8'h40, 8'h60, 8'h70: len = 8'd12;
      8'h41: len = 8'd16;
      8'h50: len = 8'd11;
      8'h51, 8'h52: len = 8'd4;
      8'h68: len = 8'd20;
      8'h80: len = 8'd1;
      default: len = 8'd0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/imu_tlv_front.sv
// Front part: sync hunt, header, Fletcher-8 sum and record collection.
// Depends on imu_tlv_pkg.
module imu_tlv_front import imu_tlv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   sync_first,
  input  logic [7:0]   sync_second,
  output logic         ev_valid,
  output event_t       ev
);

  phase_t phase, phase_next;
  logic [15:0] tid_reg;
  logic [7:0] payload_left, sum_low, sum_high, rx_check_low, rec_id, rec_len;
  logic [RecCountW-1:0] rec_count;
  logic [MaxRecordBytes*8-1:0] rec_bytes;

  logic [7:0] left_dec, sum_low_add, want;
  logic [RecCountW-1:0] count_inc;
  logic rec_match, rec_done;

  assign left_dec = payload_left - 8'd1;
  assign sum_low_add = sum_low + rx_byte;
  assign want = expected_len(rec_id);
  assign rec_match = (want != 8'd0) && (rx_byte == want) && (rx_byte <= left_dec)
                     && (rx_byte <= 8'(MaxRecordBytes));
  assign count_inc = rec_count + 1'b1;
  assign rec_done = {3'd0, count_inc} >= rec_len;

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_SYNC1: if (rx_byte == sync_first) phase_next = PH_SYNC2;
      PH_SYNC2: begin
        if (rx_byte == sync_second) phase_next = PH_TID0;
        else if (rx_byte != sync_first) phase_next = PH_SYNC1;
      end
      PH_TID0: phase_next = PH_TID1;
      PH_TID1: phase_next = PH_LEN;
      PH_LEN: phase_next = (rx_byte == 8'd0) ? PH_CK1 : PH_RID;
      PH_RID: phase_next = (left_dec == 8'd0) ? PH_CK1 : PH_RLEN;
      PH_RLEN: begin
        if (rec_match) phase_next = PH_RDATA;
        else phase_next = (left_dec == 8'd0) ? PH_CK1 : PH_RLEN;
      end
      PH_RDATA: begin
        if (rec_done) phase_next = (left_dec == 8'd0) ? PH_CK1 : PH_RID;
        else if (left_dec == 8'd0) phase_next = PH_CK1;
      end
      PH_CK1: phase_next = PH_CK2;
      PH_CK2: phase_next = PH_SYNC1;
      default: phase_next = PH_SYNC1;
    endcase
  end

  // Event outputs for the current byte.
  always_comb begin
    ev_valid = 1'b0;
    ev.is_frame = 1'b0;
    ev.id = rec_id;
    ev.data = rec_bytes;
    ev.data[rec_count*8 +: 8] = rx_byte;
    ev.ok = (rx_check_low == sum_low) && (rx_byte == sum_high);
    ev.tid = tid_reg;
    unique case (phase)
      PH_RDATA: ev_valid = in_valid && rec_done;
      PH_CK2: begin
        ev_valid = in_valid;
        ev.is_frame = 1'b1;
      end
      default: ev_valid = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
      tid_reg <= '0;
      payload_left <= '0;
      sum_low <= '0;
      sum_high <= '0;
      rx_check_low <= '0;
      rec_id <= '0;
      rec_len <= '0;
      rec_count <= '0;
    end else if (in_valid) begin
      phase <= phase_next;
      case (phase)
        PH_SYNC2: if (rx_byte == sync_second) begin
          sum_low <= '0;
          sum_high <= '0;
        end
        PH_TID0, PH_TID1, PH_LEN, PH_RID, PH_RLEN, PH_RDATA: begin
          sum_low <= sum_low_add;
          sum_high <= sum_high + sum_low_add;
        end
        default: ;
      endcase
      case (phase)
        PH_TID0: tid_reg <= {8'd0, rx_byte};
        PH_TID1: tid_reg[15:8] <= rx_byte;
        PH_LEN: payload_left <= rx_byte;
        PH_RID: begin
          payload_left <= left_dec;
          rec_id <= rx_byte;
        end
        PH_RLEN: begin
          payload_left <= left_dec;
          if (rec_match) begin
            rec_len <= rx_byte;
            rec_count <= '0;
          end else begin
            rec_id <= rx_byte;
          end
        end
        PH_RDATA: begin
          payload_left <= left_dec;
          rec_count <= count_inc;
        end
        PH_CK1: rx_check_low <= rx_byte;
        default: ;
      endcase
    end
  end

  // Record data bytes; count stays below the table maximum.
  always_ff @(posedge clk) begin
    if (in_valid && phase == PH_RDATA) rec_bytes[rec_count*8 +: 8] <= rx_byte;
  end

endmodule

### hw/rtl/imu_tlv_back.sv
// Back part: event queue and formatting of record and frame results.
// Depends on imu_tlv_pkg.
module imu_tlv_back import imu_tlv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         ev_valid,
  input  event_t       ev,
  output logic         q_full,
  output logic         empty,
  input  logic         pop,
  output logic         result_kind,
  output logic [7:0]   record_id,
  output logic signed [63:0] value_a,
  output logic signed [63:0] value_b,
  output logic signed [31:0] value_c,
  output logic signed [31:0] value_d,
  output logic         frame_ok,
  output logic [15:0]  frame_tid
);

  event_t q [QueueDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] count;
  logic do_push, do_pop;
  event_t h;
  logic [MaxRecordBytes*8-1:0] d;

  assign q_full = (count == 2'(QueueDepth));
  assign empty = (count == 2'd0);
  assign do_push = ev_valid && !q_full;
  assign do_pop = pop && !empty;
  assign h = q[rd_ptr];
  assign d = h.data;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q[wr_ptr] <= ev;
  end

  // Format the head entry by record id.
  always_comb begin
    result_kind = h.is_frame;
    record_id = '0;
    value_a = '0;
    value_b = '0;
    value_c = '0;
    value_d = '0;
    frame_ok = 1'b0;
    frame_tid = h.tid;
    if (h.is_frame) begin
      frame_ok = h.ok;
    end else begin
      record_id = h.id;
      case (h.id)
        8'h01: value_a = 64'(signed'(d[15:0]));
        8'h41: begin
          value_a = 64'(signed'(d[31:0]));
          value_b = 64'(signed'(d[63:32]));
          value_c = d[95:64];
          value_d = d[127:96];
        end
        8'h50: begin
          value_a = d[63:0];
          value_b = {40'd0, d[87:64]};
        end
        8'h51, 8'h52: value_a = {32'd0, d[31:0]};
        8'h68: begin
          value_a = d[63:0];
          value_b = d[127:64];
          value_c = d[159:128];
        end
        8'h80: value_a = {56'd0, d[7:0]};
        default: begin
          value_a = 64'(signed'(d[31:0]));
          value_b = 64'(signed'(d[63:32]));
          value_c = d[95:64];
        end
      endcase
    end
  end

endmodule

### hw/rtl/imu_frame_tlv_parser.sv
// Top level of the IMU frame TLV parser: config registers, front and back.
// Depends on imu_tlv_pkg, imu_tlv_front and imu_tlv_back.
//
//   channel   handshake        payload
//   input     push / full      rx_byte
//   result    empty / pop      result_kind .. frame_tid
//   config    cfg_we           cfg_index, cfg_data
//
// One byte is taken every cycle while full is low; a result is queued in the cycle after its byte.
// The two-entry result queue sets the rate: full rises only while both
// entries wait, so input stalls only while the consumer holds off pop.
// Reset is synchronous and restores the default sync bytes.
module imu_frame_tlv_parser import imu_tlv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [7:0]   rx_byte,
  output logic         empty,
  input  logic         pop,
  output logic         result_kind,
  output logic [7:0]   record_id,
  output logic signed [63:0] value_a,
  output logic signed [63:0] value_b,
  output logic signed [31:0] value_c,
  output logic signed [31:0] value_d,
  output logic         frame_ok,
  output logic [15:0]  frame_tid,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);

  logic [7:0] sync_first, sync_second;
  logic ev_valid, q_full;
  event_t ev;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first <= 8'h59;
      sync_second <= 8'h53;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_FIRST: sync_first <= cfg_data;
        CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  imu_tlv_front u_front (
    .clk, .rst,
    .in_valid(push && !q_full),
    .rx_byte, .sync_first, .sync_second,
    .ev_valid, .ev
  );

  imu_tlv_back u_back (
    .clk, .rst, .ev_valid, .ev, .q_full, .empty, .pop,
    .result_kind, .record_id, .value_a, .value_b, .value_c, .value_d,
    .frame_ok, .frame_tid
  );

endmodule
